>>> hw/rtl/linked_queue_with_free_list_defines.svh
// assertion macros for the linked queue with free list
`ifndef LINKED_QUEUE_WITH_FREE_LIST_DEFINES_SVH
`define LINKED_QUEUE_WITH_FREE_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LQFL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LQFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lqfl_pkg.sv
// shared types, codes and microcode table for the linked queue with free list
package lqfl_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned PC_W         = 4;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_ADD       = 4'd1;
  localparam logic [PC_W-1:0] PC_ADD_W     = 4'd2;
  localparam logic [PC_W-1:0] PC_REM       = 4'd3;
  localparam logic [PC_W-1:0] PC_REM_WALK  = 4'd4;
  localparam logic [PC_W-1:0] PC_DEL       = 4'd5;
  localparam logic [PC_W-1:0] PC_DEL_WALK  = 4'd6;
  localparam logic [PC_W-1:0] PC_UNLINK_A  = 4'd7;
  localparam logic [PC_W-1:0] PC_UNLINK_B  = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT       = 4'd9;
  localparam logic [PC_W-1:0] PC_FULL      = 4'd10;
  localparam logic [PC_W-1:0] PC_EMPTY     = 4'd11;
  localparam logic [PC_W-1:0] PC_NOTFOUND  = 4'd12;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_ADD,
    OP_ADV,
    OP_UNLINK_A,
    OP_UNLINK_B,
    OP_EMIT,
    OP_ST_FULL,
    OP_ST_EMPTY,
    OP_ST_NF
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_FREE_NULL,
    C_HEAD_NULL,
    C_LINK_END,
    C_MATCH,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_FREE,
    RD_NEXT
  } rd_e;

  typedef struct packed {
    op_e             op;
    rd_e             rd;
    cond_e           c1;
    logic [PC_W-1:0] t1;
    cond_e           c2;
    logic [PC_W-1:0] t2;
    logic [PC_W-1:0] nxt;
    logic            dsp;
  } ctrl_t;

  typedef struct packed {
    logic free_null;
    logic head_null;
    logic link_end;
    logic match;
  } dp_flags_t;

  typedef struct packed {
    logic      no_in;
    logic      out_busy;
    dp_flags_t dp;
  } flags_t;

  function automatic ctrl_t mk(op_e op, rd_e rd, cond_e c1, logic [PC_W-1:0] t1,
                               cond_e c2, logic [PC_W-1:0] t2,
                               logic [PC_W-1:0] nxt, logic dsp);
    ctrl_t w;
    w.op  = op;
    w.rd  = rd;
    w.c1  = c1;
    w.t1  = t1;
    w.c2  = c2;
    w.t2  = t2;
    w.nxt = nxt;
    w.dsp = dsp;
    return w;
  endfunction

  // microcode: op and read run only when neither jump is taken
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t uc;
    case (pc)
      PC_IDLE:     uc = mk(OP_ACCEPT, RD_NONE, C_NO_IN, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_IDLE, 1'b1);
      PC_ADD:      uc = mk(OP_NOP, RD_FREE, C_FREE_NULL, PC_FULL, C_NEVER, PC_IDLE,
                           PC_ADD_W, 1'b0);
      PC_ADD_W:    uc = mk(OP_ADD, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_OUT, 1'b0);
      PC_REM:      uc = mk(OP_NOP, RD_CUR, C_HEAD_NULL, PC_EMPTY, C_NEVER, PC_IDLE,
                           PC_REM_WALK, 1'b0);
      PC_REM_WALK: uc = mk(OP_ADV, RD_NEXT, C_LINK_END, PC_UNLINK_A, C_NEVER, PC_IDLE,
                           PC_REM_WALK, 1'b0);
      PC_DEL:      uc = mk(OP_NOP, RD_CUR, C_HEAD_NULL, PC_NOTFOUND, C_NEVER, PC_IDLE,
                           PC_DEL_WALK, 1'b0);
      PC_DEL_WALK: uc = mk(OP_ADV, RD_NEXT, C_MATCH, PC_UNLINK_A, C_LINK_END,
                           PC_NOTFOUND, PC_DEL_WALK, 1'b0);
      PC_UNLINK_A: uc = mk(OP_UNLINK_A, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_UNLINK_B, 1'b0);
      PC_UNLINK_B: uc = mk(OP_UNLINK_B, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_OUT, 1'b0);
      PC_OUT:      uc = mk(OP_EMIT, RD_NONE, C_OUT_BUSY, PC_OUT, C_NEVER, PC_IDLE,
                           PC_IDLE, 1'b0);
      PC_FULL:     uc = mk(OP_ST_FULL, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_OUT, 1'b0);
      PC_EMPTY:    uc = mk(OP_ST_EMPTY, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_OUT, 1'b0);
      PC_NOTFOUND: uc = mk(OP_ST_NF, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_OUT, 1'b0);
      default:     uc = mk(OP_NOP, RD_NONE, C_NEVER, PC_IDLE, C_NEVER, PC_IDLE,
                           PC_IDLE, 1'b0);
    endcase
    return uc;
  endfunction

  function automatic logic [PC_W-1:0] dispatch(logic [1:0] kind);
    logic [PC_W-1:0] pc;
    case (kind)
      KIND_ADD:    pc = PC_ADD;
      KIND_REMOVE: pc = PC_REM;
      KIND_DELETE: pc = PC_DEL;
      KIND_NOP:    pc = PC_OUT;
      default:     pc = PC_OUT;
    endcase
    return pc;
  endfunction

endpackage

>>> hw/rtl/linked_queue_with_free_list.sv
// top level: linked queue with free list, microcoded sequencer and output register
//
// Request channel in_*: kind (add, remove oldest, delete value) and value. One
// transaction is taken when in_valid_i is high and in_stall_o low; in_stall_o
// is low only while the block is idle, so requests are handled one at a time.
// Response channel out_*: status, data_out and count, held in an output
// register until out_stall_i is low at a clock edge.
// How long a request takes depends on its kind: remove oldest walks all n
// elements held; delete value walks up to the match, the k-th element from
// the newest, or the whole list when the value is absent; empty and full
// requests and the unused kind need no walk. The list walk reads one slot
// per cycle from the single-port slot memories.
// The next request is taken the cycle after the response is registered.
// A stalled response stays in the output register; the next request is still
// taken and worked on, then its response waits at the output step, holding off
// further requests, until the output register is free to load.
// Reset empties the queue and chains all slots onto the free list at once;
// no clearing pass is needed and the first request is taken right away.
module linked_queue_with_free_list
  import lqfl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  ctrl_t     ctl;
  logic      exec;
  flags_t    flags;
  dp_flags_t dp_flags;
  rsp_t      rsp;
  logic      out_valid_q, out_valid_d;
  rsp_t      out_q;
  logic      emit;

  assign flags.no_in    = !in_valid_i;
  assign flags.out_busy = out_valid_q && out_stall_i;
  assign flags.dp       = dp_flags;

  lqfl_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .kind_i  (in_data_i.kind),
    .ctl_o   (ctl),
    .exec_o  (exec)
  );

  lqfl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .exec_i  (exec),
    .req_i   (in_data_i),
    .flags_o (dp_flags),
    .rsp_o   (rsp)
  );

  assign emit = exec && (ctl.op == OP_EMIT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= rsp;
    end
  end

  assign in_stall_o  = (ctl.op != OP_ACCEPT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/lqfl_sequencer.sv
// step counter, microcode lookup and jump logic
module lqfl_sequencer
  import lqfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  flags_t     flags_i,
  input  logic [1:0] kind_i,
  output ctrl_t      ctl_o,
  output logic       exec_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctl;
  logic            take1, take2;

  function automatic logic cond_true(cond_e c, flags_t f);
    logic r;
    case (c)
      C_NEVER:     r = 1'b0;
      C_NO_IN:     r = f.no_in;
      C_FREE_NULL: r = f.dp.free_null;
      C_HEAD_NULL: r = f.dp.head_null;
      C_LINK_END:  r = f.dp.link_end;
      C_MATCH:     r = f.dp.match;
      C_OUT_BUSY:  r = f.out_busy;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    ctl   = ucode(pc_q);
    take1 = cond_true(ctl.c1, flags_i);
    take2 = cond_true(ctl.c2, flags_i);
    if (take1) begin
      pc_d = ctl.t1;
    end else if (take2) begin
      pc_d = ctl.t2;
    end else if (ctl.dsp) begin
      pc_d = dispatch(kind_i);
    end else begin
      pc_d = ctl.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o  = ctl;
  assign exec_o = !take1 && !take2;

endmodule

>>> hw/rtl/lqfl_datapath.sv
// list registers, slot memories and result registers driven by the microcode
module lqfl_datapath
  import lqfl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctl_i,
  input  logic      exec_i,
  input  req_t      req_i,
  output dp_flags_t flags_o,
  output rsp_t      rsp_o
);

  `include "linked_queue_with_free_list_defines.svh"

  localparam int unsigned SlotW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SlotW-1:0] NullSlot = SlotW'(CAPACITY);

  logic [SlotW-1:0] link_mem [CAPACITY];
  logic [31:0]      val_mem  [CAPACITY];

  logic [SlotW-1:0] head_q, head_d, free_q, free_d, cur_q, cur_d, prev_q, prev_d;
  logic [SlotW-1:0] cnt_q, cnt_d, fill_q, fill_d, steps_q, steps_d;
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [SlotW-1:0] link_rd_q, link_eff;
  logic [31:0]      val_rd_q;
  logic [1:0]       kind_q, kind_d, status_q, status_d;
  logic [31:0]      val_q, val_d, data_q, data_d;

  logic             rd_en;
  logic             lnk_we, val_we;
  logic [IdxW-1:0]  lnk_waddr, val_waddr;
  logic [SlotW-1:0] lnk_wdata;
  logic             run;

  assign run = exec_i;

  // untouched slots at or above the fill mark read as linked to the next slot, the reset chain
  assign link_eff = (rd_slot_q >= fill_q) ? rd_slot_q + 1'b1 : link_rd_q;

  always_comb begin
    case (ctl_i.rd)
      RD_CUR:  rd_slot_d = cur_q;
      RD_FREE: rd_slot_d = free_q;
      RD_NEXT: rd_slot_d = link_eff;
      default: rd_slot_d = rd_slot_q;
    endcase
    rd_en = run && (ctl_i.rd != RD_NONE);
  end

  always_comb begin
    head_d    = head_q;
    free_d    = free_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    steps_d   = steps_q;
    kind_d    = kind_q;
    val_d     = val_q;
    status_d  = status_q;
    data_d    = data_q;
    lnk_we    = 1'b0;
    val_we    = 1'b0;
    lnk_waddr = free_q[IdxW-1:0];
    val_waddr = free_q[IdxW-1:0];
    lnk_wdata = head_q;
    if (run) begin
      case (ctl_i.op)
        OP_ACCEPT: begin
          kind_d   = req_i.kind;
          val_d    = req_i.value;
          cur_d    = head_q;
          prev_d   = NullSlot;
          steps_d  = '0;
          status_d = ST_OK;
          data_d   = '0;
        end
        OP_ADD: begin
          val_we    = 1'b1;
          lnk_we    = 1'b1;
          lnk_wdata = head_q;
          head_d    = free_q;
          free_d    = link_eff;
          cnt_d     = cnt_q + 1'b1;
          if (free_q == fill_q) begin
            fill_d = fill_q + 1'b1;
          end
        end
        OP_ADV: begin
          prev_d  = cur_q;
          cur_d   = link_eff;
          steps_d = steps_q + 1'b1;
        end
        OP_UNLINK_A: begin
          if (prev_q == NullSlot) begin
            head_d = link_eff;
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_q[IdxW-1:0];
            lnk_wdata = link_eff;
          end
          if (kind_q == KIND_REMOVE) begin
            data_d = val_rd_q;
          end
        end
        OP_UNLINK_B: begin
          lnk_we    = 1'b1;
          lnk_waddr = cur_q[IdxW-1:0];
          lnk_wdata = free_q;
          free_d    = cur_q;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_ST_FULL:  status_d = ST_FULL;
        OP_ST_EMPTY: status_d = ST_EMPTY;
        OP_ST_NF:    status_d = ST_NOTFOUND;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= NullSlot;
      free_q    <= '0;
      cur_q     <= NullSlot;
      prev_q    <= NullSlot;
      cnt_q     <= '0;
      fill_q    <= '0;
      steps_q   <= '0;
      rd_slot_q <= '0;
      kind_q    <= KIND_NOP;
      status_q  <= ST_OK;
    end else begin
      head_q   <= head_d;
      free_q   <= free_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      steps_q  <= steps_d;
      kind_q   <= kind_d;
      status_q <= status_d;
      if (rd_en) begin
        rd_slot_q <= rd_slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    data_q <= data_d;
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    if (val_we) begin
      val_mem[val_waddr] <= val_q;
    end
    if (rd_en) begin
      link_rd_q <= link_mem[rd_slot_d[IdxW-1:0]];
      val_rd_q  <= val_mem[rd_slot_d[IdxW-1:0]];
    end
  end

  assign flags_o.free_null = (free_q == NullSlot);
  assign flags_o.head_null = (head_q == NullSlot);
  assign flags_o.link_end  = (link_eff == NullSlot) || (steps_q >= NullSlot);
  assign flags_o.match     = (val_rd_q == val_q);

  assign rsp_o.status   = status_q;
  assign rsp_o.data_out = data_q;
  assign rsp_o.count    = COUNT_W'(cnt_q);

  `LQFL_ASSERT(a_cnt_bound, 1'b1, cnt_q <= NullSlot && fill_q <= NullSlot, "count past capacity")
  `LQFL_ASSERT(a_head_empty, ctl_i.op == OP_ACCEPT, (head_q == NullSlot) == (cnt_q == '0), "head and count disagree")
  `LQFL_ASSERT(a_free_full, ctl_i.op == OP_ACCEPT, (free_q == NullSlot) == (cnt_q == NullSlot), "free list and count disagree")
  `LQFL_ASSERT_NEXT(a_add_count, run && ctl_i.op == OP_ADD, cnt_q == $past(cnt_q) + 1'b1, "add did not bump count")

endmodule

>>> tb/testbench.sv
// self-checking testbench for the linked queue with free list
module testbench
  import lqfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_ITEMS = 650;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * (CAPACITY_DEF + 5);
  localparam int unsigned NUM_ROWS = 19;

  typedef struct packed {
    req_t       req;
    logic [4:0] reps;
    logic       typed;
    rsp_t       rsp;
  } dir_row_t;

  // directed sequence: empty cases, extremes, duplicates, fill to full, unlink head/tail
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{'{KIND_REMOVE, 32'sd0},         5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
    '{'{KIND_DELETE, 32'sd0},         5'd1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0}},
    '{'{KIND_NOP, -32'sd1},           5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd0}},
    '{'{KIND_ADD, 32'sh8000_0000},    5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd1}},
    '{'{KIND_ADD, 32'sh7fff_ffff},    5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd2}},
    '{'{KIND_ADD, 32'sd0},            5'd1,  1'b0, '0},
    '{'{KIND_ADD, -32'sd1},           5'd1,  1'b0, '0},
    '{'{KIND_ADD, 32'sd5},            5'd1,  1'b0, '0},
    '{'{KIND_ADD, 32'sd7},            5'd1,  1'b0, '0},
    '{'{KIND_ADD, 32'sd5},            5'd1,  1'b0, '0},
    '{'{KIND_DELETE, 32'sd5},         5'd1,  1'b0, '0},
    '{'{KIND_ADD, 32'sh5555_aaaa},    5'd10, 1'b0, '0},
    '{'{KIND_ADD, 32'sd1},            5'd1,  1'b1, '{ST_FULL, 32'sd0, 5'd16}},
    '{'{KIND_DELETE, 32'sd12345},     5'd1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd16}},
    '{'{KIND_NOP, 32'sd0},            5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd16}},
    '{'{KIND_REMOVE, 32'sd0},         5'd1,  1'b1, '{ST_OK, 32'sh8000_0000, 5'd15}},
    '{'{KIND_DELETE, 32'sh7fff_ffff}, 5'd1,  1'b0, '0},
    '{'{KIND_DELETE, -32'sd1},        5'd1,  1'b0, '0},
    '{'{KIND_REMOVE, -32'sd1},        5'd1,  1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  logic signed [31:0] held_values [$];
  rsp_t               pending_rsp [$];
  logic signed [31:0] value_pool [8];

  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  linked_queue_with_free_list u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // queue contents newest first
  function automatic rsp_t apply_request(req_t r);
    rsp_t rsp;
    int   hit;
    rsp = '0;
    rsp.status = ST_OK;
    hit = -1;
    case (r.kind)
      KIND_ADD: begin
        if (held_values.size() >= CAPACITY_DEF) rsp.status = ST_FULL;
        else held_values.push_front(r.value);
      end
      KIND_REMOVE: begin
        if (held_values.size() == 0) rsp.status = ST_EMPTY;
        else rsp.data_out = held_values.pop_back();
      end
      KIND_DELETE: begin
        for (int i = 0; i < held_values.size() && hit < 0; i++) begin
          if (held_values[i] == r.value) hit = i;
        end
        if (hit < 0) rsp.status = ST_NOTFOUND;
        else held_values.delete(hit);
      end
      default: begin
      end
    endcase
    rsp.count = COUNT_W'(held_values.size());
    return rsp;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_request(r);
    pending_rsp.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value(logic for_delete);
    if (for_delete && held_values.size() != 0 && $urandom_range(99) < 70)
      return held_values[$urandom_range(held_values.size() - 1)];
    if ($urandom_range(99) < 75) return value_pool[3'($urandom_range(7))];
    return $urandom;
  endfunction

  function automatic req_t random_request(logic fill_tide);
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (fill_tide) begin
      if (roll < 55) r.kind = KIND_ADD;
      else if (roll < 75) r.kind = KIND_REMOVE;
      else if (roll < 95) r.kind = KIND_DELETE;
      else r.kind = KIND_NOP;
    end else begin
      if (roll < 20) r.kind = KIND_ADD;
      else if (roll < 60) r.kind = KIND_REMOVE;
      else if (roll < 95) r.kind = KIND_DELETE;
      else r.kind = KIND_NOP;
    end
    r.value = pick_value(r.kind == KIND_DELETE);
    return r;
  endfunction

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    send_idle_pct  = 38;
    recv_stall_pct = 85;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      for (int k = 0; k < DIR_ROWS[i].reps; k++)
        send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 38;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int j = 4; j < 8; j++) value_pool[j] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 100) hold_requests++;
        if (n == 400) wait_drained();
        send_request(random_request(((n / 48) % 2) == 0), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, status %0d data_out %0d count %0d",
                 $realtime, out_data_o.status, out_data_o.data_out, out_data_o.count);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d, actual %0d",
                   $realtime, want.status, out_data_o.status);
        end
        if (out_data_o.data_out !== want.data_out) begin
          errors++;
          $display("%0t: data_out expected %0d, actual %0d",
                   $realtime, want.data_out, out_data_o.data_out);
        end
        if (out_data_o.count !== want.count) begin
          errors++;
          $display("%0t: count expected %0d, actual %0d",
                   $realtime, want.count, out_data_o.count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
